### hdl/swpm_pkg.sv
package swpm_pkg;

    localparam int PIX_W = 10;
    localparam int CF = 44;
    localparam int CW = 48;
    localparam int CN = 44;
    localparam int QW = 44;
    localparam int STEP_W = 6;
    localparam int AW = 5;
    // floor(x / 100) equals (x * SPREAD_RECIP) >> SPREAD_SHIFT for every spread product.
    localparam int SPREAD_RECIP = 671089;
    localparam int SPREAD_RW = 20;
    localparam int SPREAD_SHIFT = 26;
    localparam real PI = 3.14159265358979323846;
    localparam real TWO_OVER_PI = 2.0 / PI;

    localparam logic [2:0] REG_TABLE_LENGTH   = 3'd0;
    localparam logic [2:0] REG_SPREAD_PERCENT = 3'd1;
    localparam logic [2:0] REG_DEPTH_Q16      = 3'd2;
    localparam logic [2:0] REG_GROUP_WIDTH    = 3'd3;
    localparam logic [2:0] REG_GAP_WIDTH      = 3'd4;
    localparam logic [2:0] REG_BASE_COLOR     = 3'd5;

    typedef struct packed {
        logic [10:0] table_length;
        logic [6:0]  spread_percent;
        logic [15:0] depth_q16;
        logic [7:0]  group_width;
        logic [7:0]  gap_width;
        logic [31:0] base_color;
    } t_cfg;

    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
    } t_div_ctl;

    typedef logic signed [CW-1:0] t_atan_tab [CN];

    // Arctangent of 2^-i in units of a quarter turn, CF fraction bits.
    function automatic t_atan_tab f_atan_tab();
        t_atan_tab tab;
        real       a;
        for (int i = 0; i < CN; i++) begin
            a = $atan(2.0 ** (-i)) * TWO_OVER_PI * (2.0 ** CF);
            tab[i] = CW'(longint'(a));
        end
        return tab;
    endfunction

    function automatic logic signed [CW-1:0] f_gain();
        real p;
        p = 1.0;
        for (int i = 0; i < CN; i++) begin
            p = p * (1.0 + 2.0 ** (-2 * i));
        end
        return CW'(longint'((p ** (-0.5)) * (2.0 ** CF)));
    endfunction

    localparam t_atan_tab ATAN_TAB = f_atan_tab();
    localparam logic signed [CW-1:0] CORDIC_K = f_gain();

endpackage

### hdl/swpm_if.sv
interface swpm_in_if;
    logic                valid;
    logic                ready;
    logic                func;
    logic [9:0]          pixel_index;

    modport source (output valid, func, pixel_index, input ready);
    modport sink (input valid, func, pixel_index, output ready);
endinterface

interface swpm_out_if;
    logic       valid;
    logic       ready;
    logic       written;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_white;

    modport source (output valid, written, out_red, out_green, out_blue, out_white, input ready);
    modport sink (input valid, written, out_red, out_green, out_blue, out_white, output ready);
endinterface

### hdl/swpm_cfg.sv
module swpm_cfg (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [swpm_pkg::AW-1:0]  paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready,
    output swpm_pkg::t_cfg           o_cfg
);
    import swpm_pkg::*;

    t_cfg       r_cfg;
    logic       s_wr;
    logic [2:0] s_idx;

    assign s_wr   = psel && penable && pwrite;
    assign s_idx  = paddr[AW-1:2];
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.table_length   <= 11'd64;
            r_cfg.spread_percent <= 7'd100;
            r_cfg.depth_q16      <= 16'd16384;
            r_cfg.group_width    <= 8'd1;
            r_cfg.gap_width      <= 8'd0;
            r_cfg.base_color     <= 32'h00FF_FFFF;
        end else if (s_wr) begin
            case (s_idx)
                REG_TABLE_LENGTH:   r_cfg.table_length   <= pwdata[10:0];
                REG_SPREAD_PERCENT: r_cfg.spread_percent <= pwdata[6:0];
                REG_DEPTH_Q16:      r_cfg.depth_q16      <= pwdata[15:0];
                REG_GROUP_WIDTH:    r_cfg.group_width    <= pwdata[7:0];
                REG_GAP_WIDTH:      r_cfg.gap_width      <= pwdata[7:0];
                REG_BASE_COLOR:     r_cfg.base_color     <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (s_idx)
            REG_TABLE_LENGTH:   prdata = 32'(r_cfg.table_length);
            REG_SPREAD_PERCENT: prdata = 32'(r_cfg.spread_percent);
            REG_DEPTH_Q16:      prdata = 32'(r_cfg.depth_q16);
            REG_GROUP_WIDTH:    prdata = 32'(r_cfg.group_width);
            REG_GAP_WIDTH:      prdata = 32'(r_cfg.gap_width);
            REG_BASE_COLOR:     prdata = r_cfg.base_color;
            default:            prdata = '0;
        endcase
    end

endmodule

### hdl/swpm_div.sv
module swpm_div #(
    parameter int DVW = 11
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  swpm_pkg::t_div_ctl      i_ctl,
    input  logic [swpm_pkg::QW-1:0] i_dividend,
    input  logic [DVW-1:0]          i_rem0,
    input  logic [DVW-1:0]          i_divisor,
    output logic                    o_done,
    output logic [swpm_pkg::QW-1:0] o_quot,
    output logic [DVW-1:0]          o_rem
);
    import swpm_pkg::*;

    logic              r_busy;
    logic [STEP_W-1:0] r_cnt;
    logic [QW-1:0]     r_q;
    logic [DVW-1:0]    r_rem;
    logic [DVW-1:0]    r_dvs;
    logic [DVW:0]      s_trial;
    logic              s_ge;

    assign s_trial = {r_rem, r_q[QW-1]};
    assign s_ge    = s_trial >= {1'b0, r_dvs};
    assign o_done  = r_busy && (r_cnt == '0);
    assign o_quot  = r_q;
    assign o_rem   = r_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_ctl.start) begin
            r_busy <= 1'b1;
            r_cnt  <= i_ctl.steps;
        end else if (o_done) begin
            r_busy <= 1'b0;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    // The dividend is aligned to the top so that one bit enters the remainder per step.
    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_q   <= i_dividend << (QW - int'(i_ctl.steps));
            r_rem <= i_rem0;
            r_dvs <= i_divisor;
        end else if (r_busy && r_cnt != '0) begin
            r_q   <= {r_q[QW-2:0], s_ge};
            r_rem <= s_ge ? DVW'(s_trial - {1'b0, r_dvs}) : s_trial[DVW-1:0];
        end
    end

`ifndef SYNTHESIS
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.start |-> (!r_busy || o_done))
        else $error("divider started while busy");
    a_rem_below: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (r_rem < r_dvs))
        else $error("divider remainder not below divisor");
`endif

endmodule

### hdl/swpm_cordic.sv
module swpm_cordic (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [swpm_pkg::CF-1:0]        i_angle,
    output logic                           o_done,
    output logic signed [swpm_pkg::CW-1:0] o_cos,
    output logic signed [swpm_pkg::CW-1:0] o_sin
);
    import swpm_pkg::*;

    logic                 r_busy;
    logic [STEP_W-1:0]    r_it;
    logic signed [CW-1:0] r_x;
    logic signed [CW-1:0] r_y;
    logic signed [CW-1:0] r_z;
    logic signed [CW-1:0] s_xs;
    logic signed [CW-1:0] s_ys;

    assign s_xs   = r_x >>> r_it;
    assign s_ys   = r_y >>> r_it;
    assign o_done = r_busy && (r_it == STEP_W'(CN));
    assign o_cos  = r_x;
    assign o_sin  = r_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_it   <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_it   <= '0;
        end else if (o_done) begin
            r_busy <= 1'b0;
        end else if (r_busy) begin
            r_it <= r_it + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x <= CORDIC_K;
            r_y <= '0;
            r_z <= $signed(CW'(i_angle));
        end else if (r_busy && !o_done) begin
            if (!r_z[CW-1]) begin
                r_x <= r_x - s_ys;
                r_y <= r_y + s_xs;
                r_z <= r_z - ATAN_TAB[r_it];
            end else begin
                r_x <= r_x + s_ys;
                r_y <= r_y - s_xs;
                r_z <= r_z + ATAN_TAB[r_it];
            end
        end
    end

endmodule

### hdl/sine_wave_pixel_modulator.sv
// Computes one pixel color per request item, or advances the animation phase by one
// frame. A pixel item runs through a shared restoring divider, one quotient bit per
// cycle, for the period split, the group index, the table index, the quadrant and the
// angle fraction (44 bits); the spread factor comes from a reciprocal multiplication.
// A CORDIC unit then does one rotation per cycle over 44 rotations, followed by the
// depth product and one channel product per cycle. A pixel that falls in a gap ends
// after the period split, a pixel rejected by a zero group width or the pixel limit
// goes straight to the output register, and an advance item takes one division. The
// input is not ready while an item is being worked on; a finished result waits in
// the output register, and a new result waits until the previous one has been taken.
module sine_wave_pixel_modulator #(
    parameter int MAX_PIXELS      = 1024,
    parameter int MAX_TABLE       = 1024,
    parameter int SCALE_FRAC_BITS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    swpm_in_if.sink                 i_in,
    swpm_out_if.source              o_out,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [swpm_pkg::AW-1:0] paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);
    import swpm_pkg::*;

    localparam int NW   = $clog2(MAX_TABLE + 1);
    localparam int PH_W = $clog2(MAX_TABLE);
    localparam int DVW  = (NW > 9) ? NW : 9;
    localparam int MW   = NW + 1;
    localparam int PRW  = NW + 7;
    localparam int MQW  = PRW + SPREAD_RW;
    localparam int XW   = MW + PIX_W + 1;
    localparam int F    = SCALE_FRAC_BITS;
    localparam logic [F+1:0] ONE_X = (F+2)'(1) << F;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_ADV  = 4'd1;
    localparam logic [3:0] S_D1   = 4'd2;
    localparam logic [3:0] S_D2   = 4'd3;
    localparam logic [3:0] S_X    = 4'd5;
    localparam logic [3:0] S_D4   = 4'd6;
    localparam logic [3:0] S_D5   = 4'd7;
    localparam logic [3:0] S_D6   = 4'd8;
    localparam logic [3:0] S_COR  = 4'd9;
    localparam logic [3:0] S_DEP  = 4'd10;
    localparam logic [3:0] S_CH   = 4'd11;
    localparam logic [3:0] S_EMIT = 4'd12;

    t_cfg                 s_cfg;
    logic [3:0]           r_state;
    logic [3:0]           n_state;
    logic [PH_W-1:0]      r_phase;
    logic [PIX_W-1:0]     r_g;
    logic [MW-1:0]        r_mult;
    logic [1:0]           r_quad;
    logic                 r_swap;
    logic signed [F+1:0]  r_c;
    logic [F:0]           r_scale;
    logic [1:0]           r_ch;
    logic                 r_wr;
    logic [31:0]          r_col;
    logic                 r_ovalid;
    logic                 r_out_wr;
    logic [31:0]          r_out_col;

    t_div_ctl             s_div_ctl;
    logic [QW-1:0]        s_div_dividend;
    logic [DVW-1:0]       s_div_rem0;
    logic [DVW-1:0]       s_div_divisor;
    logic                 s_div_done;
    logic [QW-1:0]        s_div_quot;
    logic [DVW-1:0]       s_div_rem;
    logic                 s_cor_start;
    logic                 s_cor_done;
    logic signed [CW-1:0] s_cos;
    logic signed [CW-1:0] s_sin;

    logic [NW-1:0]        s_n;
    logic [8:0]           s_period;
    logic [PRW-1:0]       s_prod;
    logic [MQW-1:0]       s_mq;
    logic                 s_skip;
    logic [PIX_W+8:0]     s_bfull;
    logic [MW+PIX_W-1:0]  s_mg;
    logic [DVW:0]         s_adv;
    logic                 s_swap;
    logic [DVW-1:0]       s_m;
    logic signed [CW-1:0] s_mag;
    logic                 s_neg;
    logic [CF:0]          s_magu;
    logic [CF+1:0]        s_rsum;
    logic [F:0]           s_rmag;
    logic signed [F+1:0]  s_c;
    logic [F+1:0]         s_sum;
    logic [F+17:0]        s_dprod;
    logic [F+1:0]         s_d;
    logic [F:0]           s_scale;
    logic [7:0]           s_chan;
    logic [F+8:0]         s_cprod;
    logic                 s_emit;

    swpm_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (s_cfg)
    );

    swpm_div #(.DVW(DVW)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (s_div_ctl),
        .i_dividend (s_div_dividend),
        .i_rem0     (s_div_rem0),
        .i_divisor  (s_div_divisor),
        .o_done     (s_div_done),
        .o_quot     (s_div_quot),
        .o_rem      (s_div_rem)
    );

    swpm_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (s_cor_start),
        .i_angle (s_div_quot[CF-1:0]),
        .o_done  (s_cor_done),
        .o_cos   (s_cos),
        .o_sin   (s_sin)
    );

    always_comb begin
        if (s_cfg.table_length == '0) begin
            s_n = NW'(1);
        end else if (32'(s_cfg.table_length) > 32'(MAX_TABLE)) begin
            s_n = NW'(MAX_TABLE);
        end else begin
            s_n = NW'(s_cfg.table_length);
        end
    end

    assign s_period = 9'(s_cfg.group_width) + 9'(s_cfg.gap_width);
    assign s_prod   = PRW'(s_cfg.spread_percent) * PRW'(s_n);
    assign s_mq     = MQW'(s_prod) * MQW'(SPREAD_RECIP);
    assign s_skip   = (s_cfg.group_width == '0) ||
                      (32'(i_in.pixel_index) >= 32'(MAX_PIXELS));
    assign s_bfull  = s_div_quot[PIX_W-1:0] * s_period;
    assign s_mg     = r_mult * r_g;
    assign s_adv    = (DVW+1)'(s_div_rem) + (DVW+1)'(1);
    assign s_swap   = {s_div_rem, 1'b0} > (DVW+1)'(s_n);
    assign s_m      = s_swap ? DVW'(s_n) - s_div_rem : s_div_rem;

    // Octant folding: cosine and sine swap above an eighth turn, then the quadrant
    // picks the magnitude and the sign.
    always_comb begin
        case (r_quad)
            2'd0:    begin s_mag = r_swap ? s_sin : s_cos; s_neg = 1'b0; end
            2'd1:    begin s_mag = r_swap ? s_cos : s_sin; s_neg = 1'b1; end
            2'd2:    begin s_mag = r_swap ? s_sin : s_cos; s_neg = 1'b1; end
            default: begin s_mag = r_swap ? s_cos : s_sin; s_neg = 1'b0; end
        endcase
    end

    assign s_magu  = s_mag[CW-1] ? '0 : s_mag[CF:0];
    assign s_rsum  = (CF+2)'(s_magu) + ((CF+2)'(1) << (CF - F - 1));
    assign s_rmag  = (F+1)'(s_rsum >> (CF - F));
    assign s_c     = s_neg ? -$signed({1'b0, s_rmag}) : $signed({1'b0, s_rmag});
    assign s_sum   = ONE_X + $unsigned(r_c);
    assign s_dprod = s_cfg.depth_q16 * s_sum;
    assign s_d     = s_dprod[F+17:16];
    assign s_scale = (s_d >= ONE_X) ? '0 : (F+1)'(ONE_X - s_d);
    assign s_chan  = s_cfg.base_color[{r_ch, 3'b000} +: 8];
    assign s_cprod = s_chan * r_scale;
    assign s_emit  = (r_state == S_EMIT) && (!r_ovalid || o_out.ready);

    always_comb begin
        n_state        = r_state;
        s_div_ctl      = '0;
        s_div_dividend = '0;
        s_div_rem0     = '0;
        s_div_divisor  = DVW'(s_n);
        s_cor_start    = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    if (i_in.func) begin
                        s_div_ctl.start = 1'b1;
                        s_div_ctl.steps = STEP_W'(PH_W);
                        s_div_dividend  = QW'(r_phase);
                        n_state         = S_ADV;
                    end else if (s_skip) begin
                        n_state = S_EMIT;
                    end else begin
                        s_div_ctl.start = 1'b1;
                        s_div_ctl.steps = STEP_W'(PIX_W);
                        s_div_dividend  = QW'(i_in.pixel_index);
                        s_div_divisor   = DVW'(s_period);
                        n_state         = S_D1;
                    end
                end
            end
            S_ADV: begin
                if (s_div_done) begin
                    n_state = S_IDLE;
                end
            end
            S_D1: begin
                if (s_div_done) begin
                    if (s_div_rem >= DVW'(s_cfg.group_width)) begin
                        n_state = S_EMIT;
                    end else begin
                        s_div_ctl.start = 1'b1;
                        s_div_ctl.steps = STEP_W'(PIX_W);
                        s_div_dividend  = QW'(s_bfull[PIX_W-1:0]);
                        s_div_divisor   = DVW'(s_cfg.group_width);
                        n_state         = S_D2;
                    end
                end
            end
            S_D2: begin
                if (s_div_done) begin
                    n_state = S_X;
                end
            end
            S_X: begin
                s_div_ctl.start = 1'b1;
                s_div_ctl.steps = STEP_W'(XW);
                s_div_dividend  = QW'(s_mg) + QW'(r_phase);
                n_state         = S_D4;
            end
            S_D4: begin
                if (s_div_done) begin
                    s_div_ctl.start = 1'b1;
                    s_div_ctl.steps = STEP_W'(NW + 2);
                    s_div_dividend  = QW'({s_div_rem, 2'b00});
                    n_state         = S_D5;
                end
            end
            S_D5: begin
                if (s_div_done) begin
                    s_div_ctl.start = 1'b1;
                    s_div_ctl.steps = STEP_W'(CF);
                    s_div_rem0      = s_m;
                    n_state         = S_D6;
                end
            end
            S_D6: begin
                if (s_div_done) begin
                    s_cor_start = 1'b1;
                    n_state     = S_COR;
                end
            end
            S_COR: begin
                if (s_cor_done) begin
                    n_state = S_DEP;
                end
            end
            S_DEP: begin
                n_state = S_CH;
            end
            S_CH: begin
                if (r_ch == 2'd3) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (s_emit) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_phase  <= '0;
            r_ch     <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_ADV && s_div_done) begin
                r_phase <= (s_adv == (DVW+1)'(s_n)) ? '0 : PH_W'(s_adv);
            end
            if (r_state == S_DEP) begin
                r_ch <= '0;
            end else if (r_state == S_CH) begin
                r_ch <= r_ch + 1'b1;
            end
            if (s_emit) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (i_in.valid && !i_in.func) begin
                    r_wr  <= 1'b0;
                    r_col <= '0;
                end
            end
            S_D2: begin
                if (s_div_done) begin
                    r_g    <= s_div_quot[PIX_W-1:0];
                    r_mult <= (s_prod == '0) ? MW'(1) : s_mq[SPREAD_SHIFT +: MW];
                end
            end
            S_D5: begin
                if (s_div_done) begin
                    r_quad <= s_div_quot[1:0];
                    r_swap <= s_swap;
                end
            end
            S_COR: begin
                if (s_cor_done) begin
                    r_c <= s_c;
                end
            end
            S_DEP: begin
                r_scale <= s_scale;
                r_wr    <= 1'b1;
            end
            S_CH: begin
                r_col[{r_ch, 3'b000} +: 8] <= s_cprod[F+7:F];
            end
            default: ;
        endcase
        if (s_emit) begin
            r_out_wr  <= r_wr;
            r_out_col <= r_col;
        end
    end

    assign i_in.ready      = (r_state == S_IDLE);
    assign o_out.valid     = r_ovalid;
    assign o_out.written   = r_out_wr;
    assign o_out.out_red   = r_out_col[23:16];
    assign o_out.out_green = r_out_col[15:8];
    assign o_out.out_blue  = r_out_col[7:0];
    assign o_out.out_white = r_out_col[31:24];

`ifndef SYNTHESIS
    a_phase_wraps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ADV && s_div_done) |=> (32'(r_phase) < 32'($past(s_n))))
        else $error("phase not below table length after advance");
    a_gap_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !r_out_wr) |-> (r_out_col == '0))
        else $error("unwritten pixel carries a color");
    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && r_ovalid && !o_out.ready) |=> (r_state == S_EMIT))
        else $error("result left before the previous one was taken");
`endif

endmodule

### tb/swpm_color_checker.sv
`timescale 1ns / 100ps

module swpm_color_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    swpm_in_if          pix_ch,
    swpm_out_if         col_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output int          o_errors,
    output int          o_pending
);
    import swpm_pkg::*;

    localparam logic FUNC_ADVANCE = 1'b1;
    localparam int MAX_PIX = 1024;
    localparam int MAX_LEN = 1024;
    localparam logic [63:0] HALF_PI_Q60 = 64'h1921FB54442D1847;

    typedef struct packed {
        logic       written;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] white;
    } t_color;

    t_cfg        cfg;
    logic [9:0]  frame_phase;
    t_color      color_q[$];

    function automatic logic [63:0] mul_q60(logic [63:0] a, logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[123:60];
    endfunction

    function automatic void cos_sin_series(input logic [63:0] x,
                                           output logic [63:0] c, output logic [63:0] s);
        logic [63:0] x2, tc, ts, sc, ss;
        x2 = mul_q60(x, x);
        tc = 64'd1 << 60;
        sc = tc;
        ts = x;
        ss = x;
        for (int n = 1; n <= 12; n++) begin
            tc = mul_q60(tc, x2) / 64'((2 * n - 1) * (2 * n));
            ts = mul_q60(ts, x2) / 64'((2 * n) * (2 * n + 1));
            if (n % 2 == 1) begin
                sc = sc - tc;
                ss = ss - ts;
            end else begin
                sc = sc + tc;
                ss = ss + ts;
            end
        end
        c = sc;
        s = ss;
    endfunction

    function automatic longint cos_q16(int unsigned k, int unsigned n);
        int unsigned q, rem, m;
        logic        swap, neg;
        logic [63:0] hi, r1, lo, frac, c0, s0, ca, sa, mag;
        q = (4 * k) / n;
        rem = 4 * k - q * n;
        swap = (2 * rem > n);
        m = swap ? n - rem : rem;
        hi = ({32'd0, m} << 30) / n;
        r1 = ({32'd0, m} << 30) % n;
        lo = (r1 << 30) / n;
        frac = (hi << 30) | lo;
        cos_sin_series(mul_q60(HALF_PI_Q60, frac), c0, s0);
        ca = swap ? s0 : c0;
        sa = swap ? c0 : s0;
        case (q % 4)
            0: begin mag = ca; neg = 1'b0; end
            1: begin mag = sa; neg = 1'b1; end
            2: begin mag = ca; neg = 1'b1; end
            default: begin mag = sa; neg = 1'b0; end
        endcase
        mag = (mag + (64'd1 << 43)) >> 44;
        return neg ? -longint'(mag) : longint'(mag);
    endfunction

    function automatic int unsigned table_len();
        if (cfg.table_length == 0) return 1;
        if (cfg.table_length > MAX_LEN) return MAX_LEN;
        return cfg.table_length;
    endfunction

    function automatic logic [7:0] scale_channel(logic [7:0] ch, logic [63:0] scale);
        logic [63:0] v;
        v = (64'(ch) * scale) >> 16;
        return v[7:0];
    endfunction

    function automatic t_color pixel_color(logic [9:0] pix);
        t_color      res;
        int unsigned n, period, grp, mult, k;
        logic [63:0] prod, d, scale;
        longint      c;
        res = '0;
        n = table_len();
        period = cfg.group_width + cfg.gap_width;
        if (cfg.group_width == 0 || pix >= MAX_PIX || (pix % period) >= cfg.group_width)
            return res;
        grp = ((pix / period) * period) / cfg.group_width;
        prod = 64'(cfg.spread_percent) * n;
        mult = (prod == 0) ? 1 : 32'(prod / 100);
        k = 32'((64'(mult) * grp + frame_phase) % n);
        c = cos_q16(k, n);
        d = (64'(cfg.depth_q16) * 64'(65536 + c)) >> 16;
        scale = (d >= 65536) ? 64'd0 : 64'd65536 - d;
        res.written = 1'b1;
        res.red   = scale_channel(cfg.base_color[23:16], scale);
        res.green = scale_channel(cfg.base_color[15:8], scale);
        res.blue  = scale_channel(cfg.base_color[7:0], scale);
        res.white = scale_channel(cfg.base_color[31:24], scale);
        return res;
    endfunction

    task automatic report_mismatch(string field, int got, int want);
        $display("mismatch in %s: got %0d, expected %0d at %0t", field, got, want, $realtime);
        o_errors++;
    endtask

    initial begin
        o_errors = 0;
        o_pending = 0;
    end

    always @(posedge i_clk) begin
        t_color got, want;
        if (!i_rst_n) begin
            cfg.table_length   <= 11'd64;
            cfg.spread_percent <= 7'd100;
            cfg.depth_q16      <= 16'd16384;
            cfg.group_width    <= 8'd1;
            cfg.gap_width      <= 8'd0;
            cfg.base_color     <= 32'h00FFFFFF;
            frame_phase        <= '0;
            color_q.delete();
            o_pending <= 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[4:2])
                    REG_TABLE_LENGTH:   cfg.table_length   <= pwdata[10:0];
                    REG_SPREAD_PERCENT: cfg.spread_percent <= pwdata[6:0];
                    REG_DEPTH_Q16:      cfg.depth_q16      <= pwdata[15:0];
                    REG_GROUP_WIDTH:    cfg.group_width    <= pwdata[7:0];
                    REG_GAP_WIDTH:      cfg.gap_width      <= pwdata[7:0];
                    REG_BASE_COLOR:     cfg.base_color     <= pwdata;
                    default: ;
                endcase
            end
            if (pix_ch.valid && pix_ch.ready) begin
                if (pix_ch.func == FUNC_ADVANCE)
                    frame_phase <= 10'((frame_phase % table_len() + 1) % table_len());
                else
                    color_q = {color_q, pixel_color(pix_ch.pixel_index)};
            end
            if (col_ch.valid && col_ch.ready) begin
                got = {col_ch.written, col_ch.out_red, col_ch.out_green,
                       col_ch.out_blue, col_ch.out_white};
                if (color_q.size() == 0) begin
                    report_mismatch("unexpected item", 1, 0);
                end else begin
                    want = color_q.pop_front();
                    if (got.written != want.written)
                        report_mismatch("written", got.written, want.written);
                    if (got.red != want.red) report_mismatch("red", got.red, want.red);
                    if (got.green != want.green)
                        report_mismatch("green", got.green, want.green);
                    if (got.blue != want.blue) report_mismatch("blue", got.blue, want.blue);
                    if (got.white != want.white)
                        report_mismatch("white", got.white, want.white);
                end
            end
            o_pending <= color_q.size();
        end
    end
endmodule

### tb/tb.sv
`timescale 1ns / 100ps

module tb;
    import swpm_pkg::*;

    localparam logic FUNC_PIXEL   = 1'b0;
    localparam logic FUNC_ADVANCE = 1'b1;
    localparam int LIMIT = 2000000;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel, penable, pwrite, pready;
    logic [4:0]  paddr;
    logic [31:0] pwdata, prdata;
    int          errors, pending, cycles;
    int          idle_pct, stall_pct;

    swpm_in_if  pix_ch ();
    swpm_out_if col_ch ();

    sine_wave_pixel_modulator u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(pix_ch), .o_out(col_ch),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    swpm_color_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .pix_ch(pix_ch), .col_ch(col_ch),
        .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
        .paddr(paddr), .pwdata(pwdata), .o_errors(errors), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("tb: errors");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n)
            col_ch.ready <= 1'b0;
        else
            col_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    task automatic send_item(logic func, logic [9:0] pix);
        if ($urandom_range(99) < idle_pct) begin
            pix_ch.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
        end
        pix_ch.valid       <= 1'b1;
        pix_ch.func        <= func;
        pix_ch.pixel_index <= pix;
        do @(posedge i_clk); while (!pix_ch.ready);
    endtask

    task automatic drain();
        pix_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (250) @(posedge i_clk);
    endtask

    task automatic reg_write(logic [2:0] idx, logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic load_config(int len, int spread, int depth, int grp, int gap,
                               logic [31:0] color);
        reg_write(REG_TABLE_LENGTH, len);
        reg_write(REG_SPREAD_PERCENT, spread);
        reg_write(REG_DEPTH_Q16, depth);
        reg_write(REG_GROUP_WIDTH, grp);
        reg_write(REG_GAP_WIDTH, gap);
        reg_write(REG_BASE_COLOR, color);
    endtask

    task automatic random_items(int count);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(99) < 20)
                send_item(FUNC_ADVANCE, 10'($urandom));
            else
                send_item(FUNC_PIXEL, 10'($urandom));
        end
    endtask

    initial begin
        pix_ch.valid = 1'b0;
        pix_ch.func = FUNC_PIXEL;
        pix_ch.pixel_index = '0;
        col_ch.ready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        cycles = 0;
        idle_pct = 0;
        stall_pct = 0;
        i_rst_n = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_item(FUNC_PIXEL, 10'd0);
        send_item(FUNC_PIXEL, 10'd1023);
        send_item(FUNC_ADVANCE, 10'd0);
        send_item(FUNC_PIXEL, 10'd1);
        send_item(FUNC_ADVANCE, 10'h3FF);
        send_item(FUNC_PIXEL, 10'd512);
        drain();

        // Gaps, a zero spread and full white on a table of length 2.
        load_config(2, 0, 0, 255, 255, 32'hFFFFFFFF);
        for (int p = 253; p < 258; p++) send_item(FUNC_PIXEL, 10'(p));
        send_item(FUNC_PIXEL, 10'd1023);
        send_item(FUNC_ADVANCE, 10'd0);
        send_item(FUNC_PIXEL, 10'd600);
        drain();

        // Deepest modulation saturates, long table, phase left above a shorter one.
        load_config(2047, 120, 65535, 1, 0, 32'hA5C3_7E18);
        for (int i = 0; i < 5; i++) send_item(FUNC_ADVANCE, 10'd0);
        send_item(FUNC_PIXEL, 10'd0);
        send_item(FUNC_PIXEL, 10'd700);
        drain();
        reg_write(REG_TABLE_LENGTH, 0);
        send_item(FUNC_PIXEL, 10'd3);
        send_item(FUNC_ADVANCE, 10'd0);
        drain();
        load_config(1024, 1, 32768, 0, 3, 32'h5A3C_81E7);
        send_item(FUNC_PIXEL, 10'd4);
        send_item(FUNC_PIXEL, 10'd0);
        drain();
        reg_write(REG_GROUP_WIDTH, 1);
        send_item(FUNC_PIXEL, 10'd4);
        send_item(FUNC_PIXEL, 10'd1022);
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            case (ph % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 83; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 83; end
                default: begin idle_pct = 33; stall_pct = 33; end
            endcase
            load_config(($urandom_range(1) != 0) ? $urandom_range(40) : $urandom_range(2047),
                        $urandom_range(127), $urandom_range(65535),
                        ($urandom_range(3) == 0) ? $urandom_range(255) : $urandom_range(8),
                        ($urandom_range(3) == 0) ? $urandom_range(255) : $urandom_range(4),
                        $urandom);
            random_items(75);
            drain();
        end

        if (errors == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end
endmodule

### filelist.f
hdl/swpm_pkg.sv
hdl/swpm_if.sv
hdl/swpm_cfg.sv
hdl/swpm_div.sv
hdl/swpm_cordic.sv
hdl/sine_wave_pixel_modulator.sv
tb/swpm_color_checker.sv
tb/tb.sv
